FILE: src/ipap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipap_pkg
// Shared constants, codes and types of the IPv4 address pool allocator.
// ----------------------------------------------------------------------------
package ipap_pkg;

   localparam int POOL_SIZE = 256;
   localparam int IDX_W     = $clog2(POOL_SIZE);
   localparam int CNT_W     = $clog2(POOL_SIZE + 1);
   localparam int ADDR_W    = 32;

   // lease bit memory word layout
   localparam int BITS_W    = 2;
   localparam int BIT_ACT   = 0;
   localparam int BIT_KNOWN = 1;

   localparam logic [ADDR_W-1:0] POOL_LAST = ADDR_W'(POOL_SIZE - 1);
   localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_SIZE);

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NOT_LEASED  = 2'd1,
      ST_EXHAUSTED   = 2'd2,
      ST_NONE_FOUND  = 2'd3
   } status_type;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_NETWORK = 2'd0,
      REG_MASK    = 2'd1,
      REG_GATEWAY = 2'd2,
      REG_NONE    = 2'd3
   } reg_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_REL_CHECK,
      S_REL_READ,
      S_POP,
      S_POP_READ,
      S_POP_CHECK,
      S_SCAN_START,
      S_SCAN,
      S_RESP
   } state_type;

endpackage

FILE: src/ip_address_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_pool_allocator
// Leases IPv4 addresses from gateway+1 up to broadcast-1, clipped to the pool
// size, with a LIFO of released indices and a next-fit scan with wrap.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------
//  req     | in  | req_tvalid/tready   | tuser: operation; tdata: release_addr
//  rsp     | out | rsp_tvalid/tready   | tuser: status; tdata: granted, counts
//  csr     | in  | csr_we              | csr_addr: register, csr_wdata: value
//
//  A release checks the address range, then, when inside it, reads and updates
//  the lease bit memory. An allocate pops stack entries, dropping entries past
//  the range or already leased, and grants the first free one, else scans the
//  lease bits (up to 256 entries); the one read port of the lease bit memory sets the pace.
//  After reset and after every write to the network, mask or gateway register
//  a clearing pass sweeps all 256 entries of the lease bit memory; no request
//  is taken meanwhile.
//  A new request is taken while a result still waits in the output register;
//  a finished result holds until that register is free.
// ----------------------------------------------------------------------------
module ip_address_pool_allocator (
   input  logic        clock,
   input  logic        reset,
   // csr
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   // req
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] release_addr
   input  logic        req_tuser,   // [0] operation
   // rsp
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] granted_addr, [40:32] total_count,
                                    // [49:41] held_count, [58:50] free_count
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int IW = ipap_pkg::IDX_W;
   localparam int CW = ipap_pkg::CNT_W;
   localparam int AW = ipap_pkg::ADDR_W;
   localparam int BW = ipap_pkg::BITS_W;

   ipap_pkg::state_type state_ff, state_in;

   logic [AW-1:0] net_ff, mask_ff, gw_ff;
   logic [AW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] total_ff, total_in;

   logic [IW-1:0] clr_ff, clr_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic [IW-1:0] next_ff, next_in;
   logic [CW-1:0] lease_ff, lease_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] tries_ff, tries_in;

   logic [AW-1:0]        addr_ff;
   ipap_pkg::status_type res_status_ff, res_status_in;
   logic [AW-1:0]        res_granted_ff, res_granted_in;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [AW-1:0]        rsp_granted_ff;
   logic [CW-1:0]        rsp_total_ff, rsp_leased_ff, rsp_free_ff;

   // memory ports
   logic          bits_we;
   logic [IW-1:0] bits_waddr, bits_raddr;
   logic [BW-1:0] bits_wdata, bits_rdata;
   logic          stk_we;
   logic [IW-1:0] stk_waddr, stk_raddr, stk_rdata;

   logic          accept;
   logic          rsp_free;
   logic          cfg_hit;
   logic [AW-1:0] rel_off;
   logic          rel_in_range;
   logic          pop_in_range;
   logic [CW-1:0] scan_inc;
   logic [IW-1:0] scan_next;
   logic [IW-1:0] scan_first;
   logic          scan_last;

   ipap_ram #(.DATA_W(BW), .DEPTH(ipap_pkg::POOL_SIZE)) u_bits (
      .clock (clock),
      .we    (bits_we),
      .waddr (bits_waddr),
      .wdata (bits_wdata),
      .raddr (bits_raddr),
      .rdata (bits_rdata)
   );

   ipap_ram #(.DATA_W(IW), .DEPTH(ipap_pkg::POOL_SIZE)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (idx_ff),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign cfg_hit  = csr_we && (ipap_pkg::reg_type'(csr_addr) != ipap_pkg::REG_NONE);

   // range limits, registered in two steps; settled long before the clear ends
   assign lo_in = gw_ff + AW'(1);
   assign hi_in = (net_ff | ~mask_ff) - AW'(1);

   always_comb begin
      if (hi_ff < lo_ff) begin
         total_in = '0;
      end else if ((hi_ff - lo_ff) >= ipap_pkg::POOL_LAST) begin
         total_in = ipap_pkg::POOL_CNT;
      end else begin
         total_in = CW'(hi_ff - lo_ff) + CW'(1);
      end
   end

   assign rel_off      = addr_ff - lo_ff;
   assign rel_in_range = rel_off < AW'(total_ff);
   assign pop_in_range = CW'(stk_rdata) < total_ff;
   assign scan_inc     = CW'(idx_ff) + CW'(1);
   assign scan_next    = (scan_inc < total_ff) ? scan_inc[IW-1:0] : '0;
   assign scan_first   = (CW'(next_ff) < total_ff) ? next_ff : '0;
   assign scan_last    = (tries_ff == (total_ff - CW'(1)));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ipap_pkg::S_CLEAR: begin
            if (clr_ff == IW'(ipap_pkg::POOL_SIZE - 1)) state_in = ipap_pkg::S_IDLE;
         end
         ipap_pkg::S_IDLE: begin
            if (accept) begin
               state_in = (ipap_pkg::op_type'(req_tuser) == ipap_pkg::OP_RELEASE)
                          ? ipap_pkg::S_REL_CHECK : ipap_pkg::S_POP;
            end
         end
         ipap_pkg::S_REL_CHECK: begin
            state_in = rel_in_range ? ipap_pkg::S_REL_READ : ipap_pkg::S_RESP;
         end
         ipap_pkg::S_REL_READ: state_in = ipap_pkg::S_RESP;
         ipap_pkg::S_POP: begin
            state_in = (depth_ff != '0) ? ipap_pkg::S_POP_READ : ipap_pkg::S_SCAN_START;
         end
         ipap_pkg::S_POP_READ: begin
            state_in = pop_in_range ? ipap_pkg::S_POP_CHECK : ipap_pkg::S_POP;
         end
         ipap_pkg::S_POP_CHECK: begin
            state_in = bits_rdata[ipap_pkg::BIT_ACT] ? ipap_pkg::S_POP : ipap_pkg::S_RESP;
         end
         ipap_pkg::S_SCAN_START: begin
            state_in = (lease_ff >= total_ff) ? ipap_pkg::S_RESP : ipap_pkg::S_SCAN;
         end
         ipap_pkg::S_SCAN: begin
            if (!bits_rdata[ipap_pkg::BIT_ACT] || scan_last) state_in = ipap_pkg::S_RESP;
         end
         ipap_pkg::S_RESP: begin
            if (rsp_free) state_in = ipap_pkg::S_IDLE;
         end
         default: state_in = ipap_pkg::S_CLEAR;
      endcase
      // a write to the network, mask or gateway register restarts the clearing pass
      if (cfg_hit) state_in = ipap_pkg::S_CLEAR;
   end

   // datapath and memory control
   always_comb begin
      req_tready     = (state_ff == ipap_pkg::S_IDLE);
      clr_in         = clr_ff;
      depth_in       = depth_ff;
      next_in        = next_ff;
      lease_in       = lease_ff;
      idx_in         = idx_ff;
      tries_in       = tries_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      bits_we        = 1'b0;
      bits_waddr     = idx_ff;
      bits_wdata     = '0;
      bits_raddr     = idx_ff;
      stk_we         = 1'b0;
      stk_waddr      = depth_ff[IW-1:0];
      stk_raddr      = IW'(depth_ff - CW'(1));

      unique case (state_ff)
         ipap_pkg::S_CLEAR: begin
            bits_we    = 1'b1;
            bits_waddr = clr_ff;
            clr_in     = clr_ff + IW'(1);
         end
         ipap_pkg::S_IDLE: begin
            if (accept) begin
               res_status_in  = ipap_pkg::ST_OK;
               res_granted_in = '0;
            end
         end
         ipap_pkg::S_REL_CHECK: begin
            idx_in     = rel_off[IW-1:0];
            bits_raddr = rel_off[IW-1:0];
            if (!rel_in_range) res_status_in = ipap_pkg::ST_NOT_LEASED;
         end
         ipap_pkg::S_REL_READ: begin
            if (!bits_rdata[ipap_pkg::BIT_KNOWN]) begin
               res_status_in = ipap_pkg::ST_NOT_LEASED;
            end else if (bits_rdata[ipap_pkg::BIT_ACT]) begin
               bits_we                          = 1'b1;
               bits_wdata[ipap_pkg::BIT_KNOWN]  = 1'b1;
               if (depth_ff < ipap_pkg::POOL_CNT) begin
                  stk_we   = 1'b1;
                  depth_in = depth_ff + CW'(1);
               end
               if (lease_ff != '0) lease_in = lease_ff - CW'(1);
            end
         end
         ipap_pkg::S_POP: begin
            // pop and read the top entry
            if (depth_ff != '0) depth_in = depth_ff - CW'(1);
         end
         ipap_pkg::S_POP_READ: begin
            idx_in     = stk_rdata;
            bits_raddr = stk_rdata;
         end
         ipap_pkg::S_POP_CHECK: begin
            if (!bits_rdata[ipap_pkg::BIT_ACT]) begin
               bits_we        = 1'b1;
               bits_wdata     = '1;
               lease_in       = lease_ff + CW'(1);
               res_granted_in = lo_ff + AW'(idx_ff);
            end
         end
         ipap_pkg::S_SCAN_START: begin
            idx_in     = scan_first;
            bits_raddr = scan_first;
            tries_in   = '0;
            if (lease_ff >= total_ff) res_status_in = ipap_pkg::ST_EXHAUSTED;
         end
         ipap_pkg::S_SCAN: begin
            // data of idx_ff arrives while the next entry is read
            bits_raddr = scan_next;
            if (!bits_rdata[ipap_pkg::BIT_ACT]) begin
               bits_we        = 1'b1;
               bits_wdata     = '1;
               lease_in       = lease_ff + CW'(1);
               next_in        = scan_next;
               res_granted_in = lo_ff + AW'(idx_ff);
            end else if (scan_last) begin
               res_status_in = ipap_pkg::ST_NONE_FOUND;
            end else begin
               idx_in   = scan_next;
               tries_in = tries_ff + CW'(1);
            end
         end
         ipap_pkg::S_RESP: begin
         end
         default: begin
         end
      endcase

      if (cfg_hit) begin
         clr_in   = '0;
         depth_in = '0;
         next_in  = '0;
         lease_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ipap_pkg::S_CLEAR;
         net_ff       <= '0;
         mask_ff      <= '0;
         gw_ff        <= '0;
         clr_ff       <= '0;
         depth_ff     <= '0;
         next_ff      <= '0;
         lease_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         depth_ff <= depth_in;
         next_ff  <= next_in;
         lease_ff <= lease_in;
         if (csr_we) begin
            unique case (ipap_pkg::reg_type'(csr_addr))
               ipap_pkg::REG_NETWORK: net_ff  <= csr_wdata;
               ipap_pkg::REG_MASK:    mask_ff <= csr_wdata;
               ipap_pkg::REG_GATEWAY: gw_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (state_ff == ipap_pkg::S_RESP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      total_ff       <= total_in;
      idx_ff         <= idx_in;
      tries_ff       <= tries_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      if (accept) begin
         addr_ff <= req_tdata;
      end
      if (state_ff == ipap_pkg::S_RESP && rsp_free) begin
         rsp_status_ff  <= res_status_ff;
         rsp_granted_ff <= res_granted_ff;
         rsp_total_ff   <= total_ff;
         rsp_leased_ff  <= lease_ff;
         rsp_free_ff    <= (lease_ff <= total_ff) ? (total_ff - lease_ff) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'd0, rsp_free_ff, rsp_leased_ff, rsp_total_ff, rsp_granted_ff};

endmodule

FILE: src/ipap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipap_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ipap_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [$clog2(DEPTH)-1:0]  waddr,
   input  logic [DATA_W-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0]  raddr,
   output logic [DATA_W-1:0]         rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the IPv4 address pool allocator. A queue of lease
// requests feeds a clocked driver; every accepted word is run through a lease
// predictor whose expected response is compared field by field with each
// accepted response word. Directed cases come first, then random phases over
// several pool ranges, including empty, wrapping and clipped ones.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct packed {
      ipap_pkg::op_type op;
      logic [31:0]      addr;
   } pool_req_type;

   typedef struct packed {
      ipap_pkg::status_type       status;
      logic [31:0]                granted;
      logic [ipap_pkg::CNT_W-1:0] total_cnt;
      logic [ipap_pkg::CNT_W-1:0] leased_cnt;
      logic [ipap_pkg::CNT_W-1:0] free_cnt;
   } lease_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = ipap_pkg::REG_NETWORK;
   logic [31:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = ipap_pkg::OP_ALLOC;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   ip_address_pool_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // predictor copy of the registers and the pool
   logic [31:0]                net_reg, mask_reg, gw_reg;
   bit                         lease_active [ipap_pkg::POOL_SIZE];
   bit                         lease_known [ipap_pkg::POOL_SIZE];
   logic [ipap_pkg::IDX_W-1:0] freed_stack [ipap_pkg::POOL_SIZE];
   int                         freed_depth, scan_next, leases_held;

   pool_req_type  req_pending_q[$];
   lease_rsp_type expected_leases[$];
   pool_req_type  req_word;
   bit            req_offering;
   int            req_gap;
   bit            quiet_phase;
   bit            hold_request, hold_done;
   int            hold_left, stall_left;
   int            mismatch_count;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pool_total();
      logic [31:0] lo, hi;
      logic [32:0] n;
      lo = gw_reg + 32'd1;
      hi = (net_reg | ~mask_reg) - 32'd1;
      if (hi < lo) return 0;
      n = {1'b0, hi} - {1'b0, lo} + 33'd1;
      return (n > 33'(ipap_pkg::POOL_SIZE)) ? ipap_pkg::POOL_SIZE : int'(n);
   endfunction

   function automatic void clear_pool_model();
      for (int i = 0; i < ipap_pkg::POOL_SIZE; i++) begin
         lease_active[i] = 1'b0;
         lease_known[i] = 1'b0;
         freed_stack[i] = '0;
      end
      freed_depth = 0;
      scan_next = 0;
      leases_held = 0;
   endfunction

   function automatic void take_lease(int idx);
      lease_active[idx] = 1'b1;
      lease_known[idx] = 1'b1;
      leases_held++;
   endfunction

   function automatic lease_rsp_type predict_lease(pool_req_type it);
      lease_rsp_type o;
      logic [31:0]   lo, off;
      int            tot, idx, cur;
      bit            done;
      lo = gw_reg + 32'd1;
      tot = pool_total();
      o = '0;
      o.status = ipap_pkg::ST_OK;
      done = 1'b0;
      if (it.op == ipap_pkg::OP_ALLOC) begin
         // pop released indices first, dropping stale ones
         while (!done && freed_depth > 0) begin
            freed_depth--;
            idx = int'(freed_stack[freed_depth]);
            if (idx < tot && !lease_active[idx]) begin
               take_lease(idx);
               o.granted = lo + 32'(idx);
               done = 1'b1;
            end
         end
         if (!done) begin
            if (leases_held >= tot) begin
               o.status = ipap_pkg::ST_EXHAUSTED;
            end else begin
               cur = (scan_next < tot) ? scan_next : 0;
               o.status = ipap_pkg::ST_NONE_FOUND;
               for (int tries = 0; tries < tot; tries++) begin
                  if (!lease_active[cur]) begin
                     take_lease(cur);
                     o.granted = lo + 32'(cur);
                     scan_next = (cur + 1 < tot) ? cur + 1 : 0;
                     o.status = ipap_pkg::ST_OK;
                     break;
                  end
                  cur = (cur + 1 < tot) ? cur + 1 : 0;
               end
            end
         end
      end else begin
         off = it.addr - lo;
         if (off >= 32'(tot) || !lease_known[off[ipap_pkg::IDX_W-1:0]]) begin
            o.status = ipap_pkg::ST_NOT_LEASED;
         end else if (lease_active[off[ipap_pkg::IDX_W-1:0]]) begin
            lease_active[off[ipap_pkg::IDX_W-1:0]] = 1'b0;
            if (freed_depth < ipap_pkg::POOL_SIZE) begin
               freed_stack[freed_depth] = off[ipap_pkg::IDX_W-1:0];
               freed_depth++;
            end
            if (leases_held > 0) leases_held--;
         end
      end
      o.total_cnt = ipap_pkg::CNT_W'(tot);
      o.leased_cnt = ipap_pkg::CNT_W'(leases_held);
      o.free_cnt = (leases_held <= tot) ? ipap_pkg::CNT_W'(tot - leases_held) : '0;
      return o;
   endfunction

   // mostly releases inside the range, some just outside, some anywhere
   function automatic pool_req_type make_req(int alloc_pct);
      pool_req_type it;
      logic [31:0]  lo;
      int           tot, r;
      lo = gw_reg + 32'd1;
      tot = pool_total();
      it.addr = $urandom;
      if ($urandom_range(0, 99) < alloc_pct) begin
         it.op = ipap_pkg::OP_ALLOC;
      end else begin
         it.op = ipap_pkg::OP_RELEASE;
         r = $urandom_range(0, 99);
         if (tot != 0 && r < 85) it.addr = lo + $urandom_range(0, tot - 1);
         else if (r < 92) it.addr = r[0] ? lo - 32'd1 : lo + 32'(tot);
      end
      return it;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_offering = 1'b0;
         req_gap = 0;
      end else begin
         if (req_offering && req_tready) begin
            expected_leases.push_back(predict_lease(req_word));
            req_offering = 1'b0;
            req_gap = (quiet_phase || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
         end
         if (!req_offering) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (req_pending_q.size() != 0) begin
               req_word = req_pending_q.pop_front();
               req_tdata <= req_word.addr;
               req_tuser <= req_word.op;
               req_offering = 1'b1;
            end
         end
         req_tvalid <= req_offering;
      end
   end

   // response ready: random stalls plus one long hold while requests queue up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_done && req_pending_q.size() > 40) begin
         hold_done = 1'b1;
         hold_left = 800;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet_phase && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      lease_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_leases.size() == 0) begin
            $display("%0t: unexpected response word, expected none, actual %0h/%0h",
                     $time, rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_leases.pop_front();
            check_field("status", want.status, rsp_tuser);
            check_field("granted_addr", want.granted, rsp_tdata[31:0]);
            check_field("total_count", want.total_cnt, rsp_tdata[40:32]);
            check_field("held_count", want.leased_cnt, rsp_tdata[49:41]);
            check_field("free_count", want.free_cnt, rsp_tdata[58:50]);
         end
      end
   end

   task automatic write_reg(input ipap_pkg::reg_type r, input logic [31:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= r;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (r)
         ipap_pkg::REG_NETWORK: begin net_reg = v; clear_pool_model(); end
         ipap_pkg::REG_MASK: begin mask_reg = v; clear_pool_model(); end
         ipap_pkg::REG_GATEWAY: begin gw_reg = v; clear_pool_model(); end
         default: ;
      endcase
   endtask

   task automatic set_range(input logic [31:0] net, mask, gw);
      write_reg(ipap_pkg::REG_NETWORK, net);
      write_reg(ipap_pkg::REG_MASK, mask);
      write_reg(ipap_pkg::REG_GATEWAY, gw);
   endtask

   task automatic queue_req(input ipap_pkg::op_type op, input logic [31:0] addr);
      pool_req_type it;
      it.op = op;
      it.addr = addr;
      req_pending_q.push_back(it);
   endtask

   // hold until every queued word has been taken and answered
   task automatic drain();
      while (req_pending_q.size() != 0 || req_offering || expected_leases.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(input int n, input int alloc_pct);
      repeat (n) req_pending_q.push_back(make_req(alloc_pct));
      drain();
   endtask

   initial begin
      logic [31:0] m, n;
      int          k;
      net_reg = '0;
      mask_reg = '0;
      gw_reg = '0;
      clear_pool_model();
      mismatch_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset range: gateway 0, broadcast all ones, clipped to the pool
      queue_req(ipap_pkg::OP_RELEASE, 32'h0000_0000);
      queue_req(ipap_pkg::OP_RELEASE, 32'hFFFF_FFFF);
      queue_req(ipap_pkg::OP_RELEASE, 32'h0000_0001);
      repeat (3) queue_req(ipap_pkg::OP_ALLOC, 32'hFFFF_FFFF);
      queue_req(ipap_pkg::OP_RELEASE, 32'h0000_0002);
      queue_req(ipap_pkg::OP_RELEASE, 32'h0000_0002);
      queue_req(ipap_pkg::OP_RELEASE, 32'h0000_0001);
      repeat (3) queue_req(ipap_pkg::OP_ALLOC, 32'h0000_0000);
      drain();

      // three-address pool: fill it, overflow, reuse, miss on both sides
      set_range(32'h0A00_0000, 32'hFFFF_FFF8, 32'h0A00_0003);
      repeat (4) queue_req(ipap_pkg::OP_ALLOC, 32'h0);
      queue_req(ipap_pkg::OP_RELEASE, 32'h0A00_0005);
      queue_req(ipap_pkg::OP_ALLOC, 32'h0);
      queue_req(ipap_pkg::OP_RELEASE, 32'h0A00_0007);
      queue_req(ipap_pkg::OP_RELEASE, 32'h0A00_0003);
      drain();

      // gateway at the last host: empty pool
      write_reg(ipap_pkg::REG_GATEWAY, 32'h0A00_0006);
      queue_req(ipap_pkg::OP_ALLOC, 32'h0);
      queue_req(ipap_pkg::OP_RELEASE, 32'h0A00_0007);
      drain();

      set_range(32'hC0A8_0000, 32'hFFFF_FFF0, 32'hC0A8_0005);
      run_phase(300, 55);
      // unused register index leaves the pool as it is
      write_reg(ipap_pkg::REG_NONE, $urandom);
      run_phase(150, 50);

      // range wraps past zero, clipped; receiver holds off once here
      set_range(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      hold_request = 1'b1;
      run_phase(400, 75);

      quiet_phase = 1'b1;
      set_range(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
      run_phase(250, 50);
      quiet_phase = 1'b0;

      repeat (3) begin
         k = $urandom_range(2, 10);
         m = 32'hFFFF_FFFF << k;
         n = $urandom & m;
         set_range(n, m, n + $urandom_range(0, 6));
         run_phase(150, 55);
      end
      set_range($urandom, $urandom, $urandom);
      run_phase(40, 50);

      // wrapped gateway below the top: empty pool
      set_range(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFE);
      run_phase(50, 50);

      quiet_phase = 1'b1;
      set_range(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      run_phase(150, 60);

      repeat (300) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
src/ipap_pkg.sv
src/ipap_ram.sv
src/ip_address_pool_allocator.sv
verif/tb_top.sv
